@@ design/fbpa_pkg.sv @@
// package: shared constants, types and codes of the block pool allocator
`timescale 1ns / 1ps
package fbpa_pkg;

  localparam int MAX_BLOCKS   = 256;
  localparam int HEADER_BYTES = 12;

  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int LINK_W  = IDX_W + 1;
  localparam int ADDR_W  = 32;
  localparam int BSIZE_W = 16;
  localparam int COUNT_W = 9;
  localparam int SIZE_W  = BSIZE_W + 1;
  localparam int PROD_W  = LINK_W + SIZE_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [LINK_W-1:0] EMPTY_MARK = LINK_W'(MAX_BLOCKS);

  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

  typedef enum logic [1:0] {
    KIND_BUILD = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FREE  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD,
    ST_ALLOC_WB,
    ST_FREE_CMP,
    ST_FREE_DIV,
    ST_WALK,
    ST_LINK_IDX,
    ST_LINK_PRE,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [BSIZE_W-1:0] size;
    logic [COUNT_W-1:0] count;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [LINK_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] quo;
    logic             rem_zero;
  } div_sts_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              ok;
  } rsp_t;

endpackage

@@ design/fbpa_link_ram.sv @@
// module: free list link memory, one write and one registered read port
`timescale 1ns / 1ps
module fbpa_link_ram (
  input  logic                clk_i,
  input  fbpa_pkg::ram_req_t  req_i,
  output logic [fbpa_pkg::LINK_W-1:0] rd_data_o
);
  import fbpa_pkg::*;

  logic [LINK_W-1:0] mem [MAX_BLOCKS];
  logic [LINK_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

@@ design/fbpa_div.sv @@
// module: radix-2 restoring divider giving block index and exactness of an offset
`timescale 1ns / 1ps
module fbpa_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fbpa_pkg::div_req_t req_i,
  output fbpa_pkg::div_sts_t sts_o
);
  import fbpa_pkg::*;

  localparam int CNT_W = $clog2(IDX_W + 1);

  logic [PROD_W-1:0] rem_q, rem_d;
  logic [PROD_W-1:0] den_q, den_d;
  logic [IDX_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              ge;

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    ge     = rem_q >= den_q;
    if (req_i.start) begin
      rem_d  = req_i.dividend;
      den_d  = PROD_W'(req_i.divisor) << (IDX_W - 1);
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one quotient bit per cycle, msb first
      if (ge) begin
        rem_d = rem_q - den_q;
      end
      quo_d = {quo_q[IDX_W-2:0], ge};
      den_d = den_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(IDX_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign sts_o.done     = done_q;
  assign sts_o.quo      = quo_q;
  assign sts_o.rem_zero = (rem_q == '0);

endmodule

@@ design/fbpa_ctrl.sv @@
// module: request sequencer, list head and read-modify-write of the link memory
`timescale 1ns / 1ps
module fbpa_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fbpa_pkg::cfg_t               cfg_i,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  logic [1:0]                   req_kind_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]  req_address_i,
  output logic                         rsp_valid_o,
  input  logic                         rsp_ready_i,
  output fbpa_pkg::rsp_t               rsp_o,
  output fbpa_pkg::ram_req_t           ram_req_o,
  input  logic [fbpa_pkg::LINK_W-1:0]  ram_rd_i,
  output fbpa_pkg::div_req_t           div_req_o,
  input  fbpa_pkg::div_sts_t           div_sts_i
);
  import fbpa_pkg::*;

  state_e state_q, state_d;

  logic [LINK_W-1:0] head_q, head_d;
  logic [ADDR_W-1:0] off_q, off_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [LINK_W-1:0] cur_q, cur_d;
  logic              use_ram_q, use_ram_d;
  logic [LINK_W-1:0] pre_q, pre_d;
  logic [LINK_W-1:0] nxt_q, nxt_d;
  logic [LINK_W-1:0] steps_q, steps_d;
  logic [LINK_W-1:0] cnt_q, cnt_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [ADDR_W-1:0] res_q, res_d;
  logic              ok_q, ok_d;

  logic [SIZE_W-1:0] sz;
  logic [LINK_W-1:0] n;
  logic [LINK_W-1:0] mul_a;
  logic [LINK_W-1:0] cnt_inc;
  logic [LINK_W-1:0] cur;
  kind_e             kind;
  logic              cur_end;

  always_comb begin
    sz = SIZE_W'(cfg_i.size) + SIZE_W'(3);
    sz[1:0] = 2'b00;
  end

  always_comb begin
    if (int'(cfg_i.count) > MAX_BLOCKS) begin
      n = LINK_W'(MAX_BLOCKS);
    end else begin
      n = LINK_W'(cfg_i.count);
    end
  end

  assign kind    = kind_e'(req_kind_i);
  assign cnt_inc = cnt_q + 1'b1;
  assign cur     = use_ram_q ? ram_rd_i : cur_q;
  assign cur_end = cur[IDX_W] || (steps_q == LINK_W'(MAX_BLOCKS));
  assign mul_a   = (kind == KIND_ALLOC) ? head_q : n;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          if (cfg_i.size == '0) begin
            state_d = ST_RESP;
          end else begin
            unique case (kind)
              KIND_BUILD: state_d = (n == '0) ? ST_RESP : ST_BUILD;
              KIND_ALLOC: state_d = head_q[IDX_W] ? ST_RESP : ST_ALLOC_WB;
              KIND_FREE:  state_d = ST_FREE_CMP;
              default:    state_d = ST_RESP;
            endcase
          end
        end
      end
      ST_BUILD: begin
        if (cnt_inc == n) begin
          state_d = ST_RESP;
        end
      end
      ST_ALLOC_WB: state_d = ST_RESP;
      ST_FREE_CMP: begin
        state_d = (off_q >= ADDR_W'(prod_q)) ? ST_RESP : ST_FREE_DIV;
      end
      ST_FREE_DIV: begin
        if (div_sts_i.done) begin
          state_d = div_sts_i.rem_zero ? ST_WALK : ST_RESP;
        end
      end
      ST_WALK: begin
        if (cur_end || (cur[IDX_W-1:0] > idx_q)) begin
          state_d = ST_LINK_IDX;
        end
      end
      ST_LINK_IDX: state_d = ST_LINK_PRE;
      ST_LINK_PRE: state_d = ST_RESP;
      ST_RESP: begin
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    head_d    = head_q;
    off_d     = off_q;
    idx_d     = idx_q;
    cur_d     = cur_q;
    use_ram_d = use_ram_q;
    pre_d     = pre_q;
    nxt_d     = nxt_q;
    steps_d   = steps_q;
    cnt_d     = cnt_q;
    prod_d    = prod_q;
    res_d     = res_q;
    ok_d      = ok_q;
    ram_req_o = '0;
    div_req_o = '0;
    div_req_o.dividend = off_q[PROD_W-1:0];
    div_req_o.divisor  = sz;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          res_d  = '0;
          ok_d   = 1'b0;
          cnt_d  = '0;
          off_d  = req_address_i - cfg_i.base - ADDR_W'(HEADER_BYTES);
          // head times size for allocate, count times size for the free range check
          prod_d = PROD_W'(mul_a) * PROD_W'(sz);
          if ((cfg_i.size != '0) && (kind == KIND_BUILD) && (n == '0)) begin
            head_d = EMPTY_MARK;
            res_d  = cfg_i.base;
            ok_d   = 1'b1;
          end
          if ((cfg_i.size != '0) && (kind == KIND_ALLOC) && !head_q[IDX_W]) begin
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = head_q[IDX_W-1:0];
          end
        end
      end
      ST_BUILD: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = cnt_q[IDX_W-1:0];
        ram_req_o.wdata = (cnt_inc == n) ? EMPTY_MARK : cnt_inc;
        cnt_d = cnt_inc;
        if (cnt_inc == n) begin
          head_d = '0;
          res_d  = cfg_i.base;
          ok_d   = 1'b1;
        end
      end
      ST_ALLOC_WB: begin
        head_d = ram_rd_i;
        res_d  = cfg_i.base + ADDR_W'(HEADER_BYTES) + ADDR_W'(prod_q);
        ok_d   = 1'b1;
      end
      ST_FREE_CMP: begin
        if (off_q < ADDR_W'(prod_q)) begin
          div_req_o.start = 1'b1;
        end
      end
      ST_FREE_DIV: begin
        idx_d     = div_sts_i.quo;
        cur_d     = head_q;
        use_ram_d = 1'b0;
        pre_d     = EMPTY_MARK;
        nxt_d     = EMPTY_MARK;
        steps_d   = '0;
      end
      ST_WALK: begin
        // one list entry per cycle, the read data is the next entry
        if (!cur_end) begin
          if (cur[IDX_W-1:0] > idx_q) begin
            nxt_d = cur;
          end else begin
            if (cur[IDX_W-1:0] < idx_q) begin
              pre_d = cur;
            end
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = cur[IDX_W-1:0];
            use_ram_d       = 1'b1;
            steps_d         = steps_q + 1'b1;
          end
        end
      end
      ST_LINK_IDX: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = idx_q;
        ram_req_o.wdata = nxt_q;
      end
      ST_LINK_PRE: begin
        if (!pre_q[IDX_W]) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = pre_q[IDX_W-1:0];
          ram_req_o.wdata = {1'b0, idx_q};
        end else begin
          head_d = {1'b0, idx_q};
        end
        ok_d = 1'b1;
      end
      ST_RESP: begin
        rsp_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign rsp_o.address = res_q;
  assign rsp_o.ok      = ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= EMPTY_MARK;
      use_ram_q <= 1'b0;
      steps_q   <= '0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      use_ram_q <= use_ram_d;
      steps_q   <= steps_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q  <= off_d;
    idx_q  <= idx_d;
    cur_q  <= cur_d;
    pre_q  <= pre_d;
    nxt_q  <= nxt_d;
    prod_q <= prod_d;
    res_q  <= res_d;
    ok_q   <= ok_d;
  end

`ifndef SYNTHESIS
  a_no_rw_same_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req_o.we && ram_req_o.re))
    else $error("link memory read and write in one cycle");

  a_ready_excl_rsp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> !rsp_valid_o)
    else $error("request taken while a response is pending");

  a_pre_below_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LINK_PRE && !pre_q[IDX_W]) |-> (pre_q[IDX_W-1:0] < idx_q))
    else $error("predecessor not below freed block");

  a_div_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts_i.done |-> (state_q == ST_FREE_DIV))
    else $error("divider finished outside free sequence");

  a_walk_from_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_WALK) |-> $past(state_q == ST_FREE_DIV))
    else $error("list walk entered without index");
`endif

endmodule

@@ design/fixed_block_pool_allocator.sv @@
// module: top level of the fixed block pool allocator
`timescale 1ns / 1ps
// Fixed-size block pool allocator with an address-ordered free list.
// Requests come in on the s_axis channel: tuser carries the kind (rebuild,
// allocate, free) and tdata the block address for a free. Each request gives
// exactly one response on m_axis: tdata holds the result address and the ok
// flag (zero address on failure or after a free, pool base after a rebuild).
// Configuration (pool base, block size, block count) is written through
// cfg_we_i / cfg_index_i / cfg_data_i; the user must write it only while no
// request is in flight, the block itself does not enforce this.
// One request is handled at a time; the free list lives in a 256 x 9 link
// memory with a registered read and a single write port. A rebuild writes
// one link per cycle; a free checks the range, divides by the block size,
// walks the list (up to 256 entries) and links the freed block after its
// predecessor or the head, ending early out of range or off a block start.
// m_axis_tvalid rises as the sequencer returns to idle to take the next request.
// After reset the list is empty and the link memory holds no data; a rebuild
// initializes it, no clearing pass is needed.
// When the receiver stalls, the response waits in the output register and
// the sequencer holds in its response state; s_axis_tready stays low until
// the sequencer is back to idle.
module fixed_block_pool_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] address
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] result_address, [32] ok, [39:33] zero
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import fbpa_pkg::*;

  cfg_t     cfg_q, cfg_d;
  ram_req_t ram_req;
  logic [LINK_W-1:0] ram_rd;
  div_req_t div_req;
  div_sts_t div_sts;
  rsp_t     rsp;
  logic     rsp_valid;
  logic     rsp_ready;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;
  logic              out_ok_q, out_ok_d;

  // configuration registers, writes beyond the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BASE:  cfg_d.base  = cfg_data_i;
        CFG_SIZE:  cfg_d.size  = cfg_data_i[BSIZE_W-1:0];
        CFG_COUNT: cfg_d.count = cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base  <= '0;
      cfg_q.size  <= BSIZE_W'(4);
      cfg_q.count <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fbpa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_o   (s_axis_tready),
    .req_kind_i    (s_axis_tuser),
    .req_address_i (s_axis_tdata),
    .rsp_valid_o   (rsp_valid),
    .rsp_ready_i   (rsp_ready),
    .rsp_o         (rsp),
    .ram_req_o     (ram_req),
    .ram_rd_i      (ram_rd),
    .div_req_o     (div_req),
    .div_sts_i     (div_sts)
  );

  fbpa_link_ram u_link_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (ram_rd)
  );

  fbpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .sts_o  (div_sts)
  );

  // response register, loads when empty or being drained
  assign rsp_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_ok_d    = out_ok_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (rsp_valid && rsp_ready) begin
      out_valid_d = 1'b1;
      out_addr_d  = rsp.address;
      out_ok_d    = rsp.ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_addr_q <= out_addr_d;
    out_ok_q   <= out_ok_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_ok_q, out_addr_q};

endmodule
